// ===== hw/rtl/b64sd_pkg.sv =====
// Package for the base64 stream decoder: item types, queue entry type and
// the alphabet decode and byte packing functions. No dependencies.
package b64sd_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] symbol;
        logic       message_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       decode_done;
    } out_item_t;

    // One queue entry carries the one to three result items of one input item.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            has_bytes;
        logic            done;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Bit 6 set means the character is not in the standard alphabet.
    function automatic logic [6:0] sym_decode(input logic [7:0] c);
        logic [6:0] v;
        v = 7'h40;
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            v = {1'b0, 6'(c - 8'h41)};
        end
        else if (c >= 8'h61 && c <= 8'h7a)
        begin
            v = {1'b0, 6'(c - 8'h61 + 8'd26)};
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            v = {1'b0, 6'(c - 8'h30 + 8'd52)};
        end
        else if (c == 8'h2b)
        begin
            v = 7'd62;
        end
        else if (c == 8'h2f)
        begin
            v = 7'd63;
        end
        return v;
    endfunction

    function automatic logic [2:0][7:0] pack_group(input logic [5:0] s0,
                                                   input logic [5:0] s1,
                                                   input logic [5:0] s2,
                                                   input logic [5:0] s3);
        logic [2:0][7:0] b;
        b[0] = {s0, s1[5:4]};
        b[1] = {s1[3:0], s2[5:2]};
        b[2] = {s2[1:0], s3};
        return b;
    endfunction

endpackage

// ===== hw/rtl/b64sd_front.sv =====
// Front end of the base64 stream decoder: accepts characters, collects
// sextets and writes one queue entry per item that gives results. Uses b64sd_pkg.
module b64sd_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     char_valid,
    output logic                     char_ready,
    input  b64sd_pkg::in_item_t      char_item,
    input  b64sd_pkg::queue_status_t q_status,
    output logic                     push,
    output b64sd_pkg::entry_t        push_entry
);
    import b64sd_pkg::*;

    logic [5:0] store_reg [3];
    logic [5:0] store_next [3];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       halted_reg;
    logic       halted_next;
    logic [1:0] count_mid;
    logic       group_full;
    logic       accept;
    logic [6:0] sym;
    logic [5:0] flush_s2;

    assign char_ready = ~q_status.full;
    assign accept     = char_valid & char_ready;
    assign sym        = sym_decode(char_item.symbol);
    assign flush_s2   = (count_mid == 2'd3) ? store_next[2] : 6'd0;

    always_comb
    begin
        store_next  = store_reg;
        count_mid   = count_reg;
        halted_next = halted_reg;
        group_full  = 1'b0;
        if (!halted_reg)
        begin
            if (sym[6])
            begin
                halted_next = 1'b1;
            end
            else if (count_reg == 2'd3)
            begin
                group_full = 1'b1;
                count_mid  = 2'd0;
            end
            else
            begin
                store_next[count_reg] = sym[5:0];
                count_mid             = count_reg + 2'd1;
            end
        end

        push_entry.done = char_item.message_end;
        if (group_full)
        begin
            push_entry.bytes     = pack_group(store_reg[0], store_reg[1], store_reg[2],
                                              sym[5:0]);
            push_entry.last_idx  = 2'd2;
            push_entry.has_bytes = 1'b1;
        end
        else if (count_mid >= 2'd2)
        begin
            push_entry.bytes     = pack_group(store_next[0], store_next[1], flush_s2, 6'd0);
            push_entry.last_idx  = count_mid - 2'd2;
            push_entry.has_bytes = 1'b1;
        end
        else
        begin
            push_entry.bytes     = '0;
            push_entry.last_idx  = 2'd0;
            push_entry.has_bytes = 1'b0;
        end

        count_next = count_mid;
        if (char_item.message_end)
        begin
            count_next  = 2'd0;
            halted_next = 1'b0;
        end
    end

    assign push = accept & (group_full | char_item.message_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            halted_reg <= 1'b0;
        end
        else if (accept)
        begin
            count_reg  <= count_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            store_reg <= store_next;
        end
    end

endmodule

// ===== hw/rtl/b64sd_queue.sv =====
// Short queue of decoded entries between the front and back ends of the
// base64 stream decoder. Uses b64sd_pkg.
module b64sd_queue #(
    parameter int DEPTH = b64sd_pkg::QUEUE_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  b64sd_pkg::entry_t        push_entry,
    input  logic                     pop,
    output b64sd_pkg::entry_t        head,
    output b64sd_pkg::queue_status_t status
);
    import b64sd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push & ~status.full;
    assign do_pop       = pop & ~status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/b64sd_back.sv =====
// Back end of the base64 stream decoder: takes queue entries and hands out
// their result items one per cycle while res_ready is high. Uses b64sd_pkg.
module b64sd_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  b64sd_pkg::entry_t        head,
    input  b64sd_pkg::queue_status_t q_status,
    output logic                     pop,
    output logic                     res_valid,
    input  logic                     res_ready,
    output b64sd_pkg::out_item_t     res_item
);
    import b64sd_pkg::*;

    entry_t     cur_reg;
    logic       cur_valid_reg;
    logic       cur_valid_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       at_last;
    logic       taken;

    assign at_last   = (idx_reg == cur_reg.last_idx);
    assign taken     = cur_valid_reg & res_ready;
    assign pop       = ~q_status.empty & (~cur_valid_reg | (taken & at_last));
    assign res_valid = cur_valid_reg;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (taken)
        begin
            if (at_last)
            begin
                cur_valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        case (idx_reg)
            2'd0:    res_item.data_byte = cur_reg.bytes[0];
            2'd1:    res_item.data_byte = cur_reg.bytes[1];
            default: res_item.data_byte = cur_reg.bytes[2];
        endcase
        res_item.byte_valid  = cur_reg.has_bytes;
        res_item.decode_done = cur_reg.done & at_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
    end

endmodule

// ===== hw/rtl/base64_stream_decoder.sv =====
// Top level of the base64 stream decoder. Instantiates the front end, the
// entry queue and the back end; uses b64sd_pkg.
//
// The char channel takes one ASCII character per item with message_end on the
// last character of a message. The res channel gives decoded bytes, one per
// item; decode_done marks the last item of a message, and a message that
// yields no bytes gives a single item with byte_valid low.
// The front end decodes a character and, once four sextets are held or the
// message ends, writes an entry of one to three items into a queue of
// QUEUE_DEPTH entries. The back end loads an entry into its output register
// and hands its items out one per cycle while the receiver takes them.
// An accepted character's entry is registered in the queue and then in the
// output register before its first result item is offered. One character is
// accepted every cycle while the queue has space; the back end gives one item
// per cycle while the receiver takes them, so full four-character groups
// sustain one character per cycle. Reset clears the sextet count, halt flag,
// queue, output valid flag and index. When the receiver stalls, the current
// item holds, the queue fills, and char_ready falls once it is full.
module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = b64sd_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_ready,
    input  b64sd_pkg::in_item_t  char_item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output b64sd_pkg::out_item_t res_item
);
    import b64sd_pkg::*;

    logic          push;
    logic          pop;
    entry_t        push_entry;
    entry_t        head;
    queue_status_t q_status;

    b64sd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    b64sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    b64sd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

endmodule

// ===== hw/rtl/b64sd_checker.sv =====
// Port-level checks for the base64 stream decoder, attached by a bind
// statement to the top level. Uses b64sd_pkg.
module b64sd_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 res_valid,
    input logic                 res_ready,
    input b64sd_pkg::out_item_t res_item
);
    import b64sd_pkg::*;

    // A result item that is not taken must hold.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_item))
        else $error("Result item changed while stalled.");

    // An empty marker always closes its message.
    a_marker_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.byte_valid |-> res_item.decode_done)
        else $error("Empty marker without decode_done.");

    // An empty marker carries a zero byte.
    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.byte_valid |-> res_item.data_byte == 8'd0)
        else $error("Empty marker with a non-zero byte.");

    // No result item is offered as reset is released.
    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("Result offered straight out of reset.");

endmodule

bind base64_stream_decoder b64sd_checker u_b64sd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item)
);
